// ===== design/tlca_pkg.sv =====
`default_nettype none
package tlca_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_PAIR   = 2'd1;
   localparam logic [1:0] OP_KTH    = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_UNLOADED = 2'd1;
   localparam logic [1:0] ST_NO_PAR   = 2'd2;
   localparam logic [1:0] ST_BEYOND   = 2'd3;

   // register select bit (paddr[2])
   localparam logic REG_ROOT = 1'b0;

   // datapath micro-operations
   localparam logic [4:0] CMD_NOP         = 5'd0;
   localparam logic [4:0] CMD_CLEAR       = 5'd1;
   localparam logic [4:0] CMD_LATCH       = 5'd2;
   localparam logic [4:0] CMD_RD_B        = 5'd3;
   localparam logic [4:0] CMD_GET_B       = 5'd4;
   localparam logic [4:0] CMD_INS_ROOT    = 5'd5;
   localparam logic [4:0] CMD_ZERO_ANC    = 5'd6;
   localparam logic [4:0] CMD_INS_CHILD   = 5'd7;
   localparam logic [4:0] CMD_BUILD_RD    = 5'd8;
   localparam logic [4:0] CMD_BUILD_WR    = 5'd9;
   localparam logic [4:0] CMD_PAIR_SETUP  = 5'd10;
   localparam logic [4:0] CMD_K_SETUP     = 5'd11;
   localparam logic [4:0] CMD_CLIMB_STEP  = 5'd12;
   localparam logic [4:0] CMD_CLIMB_USE   = 5'd13;
   localparam logic [4:0] CMD_LIFT_INIT   = 5'd14;
   localparam logic [4:0] CMD_LIFT_RD     = 5'd15;
   localparam logic [4:0] CMD_LIFT_USE    = 5'd16;
   localparam logic [4:0] CMD_FINAL_RD    = 5'd17;
   localparam logic [4:0] CMD_FINAL_USE   = 5'd18;
   localparam logic [4:0] CMD_L_RD        = 5'd19;
   localparam logic [4:0] CMD_L_GET       = 5'd20;
   localparam logic [4:0] CMD_RES_PLAIN   = 5'd21;
   localparam logic [4:0] CMD_RES_ANC     = 5'd22;
   localparam logic [4:0] CMD_RES_PAIR    = 5'd23;

   typedef struct packed {
      logic [4:0] code;
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       a_range;
      logic       a_loaded;
      logic       b_ok;
      logic       is_root;
      logic       depth_full;
      logic       k_gt_depth;
      logic       k_zero;
      logic       k_bit0;
      logic       q_valid;
      logic       lv_last;
      logic       lv_zero;
      logic       u_eq_v;
      logic       final_ok;
      logic       l_loaded;
      logic       clr_last;
      logic       out_free;
   } flags_type;

endpackage
`default_nettype wire

// ===== design/tlca_ctrl.sv =====
`default_nettype none
module tlca_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  tlca_pkg::flags_type flags,
   output tlca_pkg::cmd_type   cmd,
   output logic                req_stall
);
   import tlca_pkg::*;

   localparam logic [4:0] S_CLEAR     = 5'd0;
   localparam logic [4:0] S_IDLE      = 5'd1;
   localparam logic [4:0] S_RDB       = 5'd2;
   localparam logic [4:0] S_GETB      = 5'd3;
   localparam logic [4:0] S_DECIDE    = 5'd4;
   localparam logic [4:0] S_ZERO      = 5'd5;
   localparam logic [4:0] S_BUILD_RD  = 5'd6;
   localparam logic [4:0] S_BUILD_WR  = 5'd7;
   localparam logic [4:0] S_CLIMB     = 5'd8;
   localparam logic [4:0] S_CLIMB_USE = 5'd9;
   localparam logic [4:0] S_CMP       = 5'd10;
   localparam logic [4:0] S_LIFT_RD   = 5'd11;
   localparam logic [4:0] S_LIFT_USE  = 5'd12;
   localparam logic [4:0] S_FINAL_RD  = 5'd13;
   localparam logic [4:0] S_FINAL_USE = 5'd14;
   localparam logic [4:0] S_L_RD      = 5'd15;
   localparam logic [4:0] S_L_GET     = 5'd16;
   localparam logic [4:0] S_RES_PLAIN = 5'd17;
   localparam logic [4:0] S_RES_ANC   = 5'd18;
   localparam logic [4:0] S_RES_PAIR  = 5'd19;

   logic [4:0] state_ff, state_in;
   logic [1:0] res_ff, res_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      res_in     = res_ff;
      cmd.code   = CMD_NOP;
      cmd.status = res_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.code = CMD_CLEAR;
            if (flags.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.code = CMD_LATCH;
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            cmd.code = CMD_RD_B;
            state_in = S_GETB;
         end
         S_GETB: begin
            cmd.code = CMD_GET_B;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_RES_PLAIN;
            res_in   = ST_UNLOADED;
            case (flags.op)
               OP_INSERT: begin
                  if (!flags.a_range || flags.a_loaded) begin
                     res_in = ST_UNLOADED;
                  end else if (flags.is_root) begin
                     cmd.code = CMD_INS_ROOT;
                     res_in   = ST_OK;
                     state_in = S_ZERO;
                  end else if (!flags.b_ok) begin
                     res_in = ST_NO_PAR;
                  end else if (flags.depth_full) begin
                     res_in = ST_BEYOND;
                  end else begin
                     cmd.code = CMD_INS_CHILD;
                     res_in   = ST_OK;
                     state_in = S_BUILD_RD;
                  end
               end
               OP_PAIR: begin
                  if (flags.a_loaded && flags.b_ok) begin
                     cmd.code = CMD_PAIR_SETUP;
                     state_in = S_CLIMB;
                  end
               end
               OP_KTH: begin
                  if (!flags.a_loaded) begin
                     res_in = ST_UNLOADED;
                  end else if (flags.k_gt_depth) begin
                     res_in = ST_BEYOND;
                  end else begin
                     cmd.code = CMD_K_SETUP;
                     state_in = S_CLIMB;
                  end
               end
               default: res_in = ST_UNLOADED;
            endcase
         end
         S_ZERO: begin
            cmd.code = CMD_ZERO_ANC;
            if (flags.lv_last) state_in = S_RES_PLAIN;
         end
         S_BUILD_RD: begin
            cmd.code = CMD_BUILD_RD;
            state_in = S_BUILD_WR;
         end
         S_BUILD_WR: begin
            cmd.code = CMD_BUILD_WR;
            state_in = flags.lv_last ? S_RES_PLAIN : S_BUILD_RD;
         end
         S_CLIMB: begin
            if (flags.k_zero) begin
               state_in = (flags.op == OP_KTH) ? S_RES_ANC : S_CMP;
            end else begin
               cmd.code = CMD_CLIMB_STEP;
               if (flags.k_bit0) state_in = S_CLIMB_USE;
            end
         end
         S_CLIMB_USE: begin
            if (!flags.q_valid) begin
               res_in   = (flags.op == OP_KTH) ? ST_BEYOND : ST_NO_PAR;
               state_in = S_RES_PLAIN;
            end else begin
               cmd.code = CMD_CLIMB_USE;
               state_in = S_CLIMB;
            end
         end
         S_CMP: begin
            if (flags.u_eq_v) begin
               state_in = S_L_RD;
            end else begin
               cmd.code = CMD_LIFT_INIT;
               state_in = S_LIFT_RD;
            end
         end
         S_LIFT_RD: begin
            cmd.code = CMD_LIFT_RD;
            state_in = S_LIFT_USE;
         end
         S_LIFT_USE: begin
            cmd.code = CMD_LIFT_USE;
            state_in = flags.lv_zero ? S_FINAL_RD : S_LIFT_RD;
         end
         S_FINAL_RD: begin
            cmd.code = CMD_FINAL_RD;
            state_in = S_FINAL_USE;
         end
         S_FINAL_USE: begin
            if (flags.final_ok) begin
               cmd.code = CMD_FINAL_USE;
               state_in = S_L_RD;
            end else begin
               res_in   = ST_NO_PAR;
               state_in = S_RES_PLAIN;
            end
         end
         S_L_RD: begin
            cmd.code = CMD_L_RD;
            state_in = S_L_GET;
         end
         S_L_GET: begin
            cmd.code = CMD_L_GET;
            state_in = S_RES_PAIR;
         end
         S_RES_PAIR: begin
            if (!flags.l_loaded) begin
               res_in   = ST_NO_PAR;
               state_in = S_RES_PLAIN;
            end else if (flags.out_free) begin
               cmd.code = CMD_RES_PAIR;
               state_in = S_IDLE;
            end
         end
         S_RES_ANC: begin
            if (flags.out_free) begin
               cmd.code = CMD_RES_ANC;
               state_in = S_IDLE;
            end
         end
         S_RES_PLAIN: begin
            if (flags.out_free) begin
               cmd.code = CMD_RES_PLAIN;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         res_ff   <= ST_OK;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/tlca_dp.sv =====
`default_nettype none
module tlca_dp #(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 11
) (
   input  wire                 clock,
   input  wire                 reset,
   input  tlca_pkg::cmd_type   cmd,
   output tlca_pkg::flags_type flags,
   input  wire  [9:0]          root_node,
   input  wire  [1:0]          req_op,
   input  wire  [9:0]          req_node_a,
   input  wire  [9:0]          req_node_b,
   input  wire  signed [15:0]  req_edge_weight,
   input  wire  [9:0]          req_steps_up,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [9:0]          rsp_lca_node,
   output logic [10:0]         rsp_hop_distance,
   output logic signed [31:0]  rsp_weight_distance,
   output logic signed [31:0]  rsp_a_to_lca,
   output logic signed [31:0]  rsp_b_to_lca,
   output logic [9:0]          rsp_ancestor_node
);
   import tlca_pkg::*;

   localparam int NW        = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
   localparam int DW        = LEVELS;
   localparam int LVW       = $clog2(LEVELS);
   localparam int KW        = (LEVELS > 10) ? LEVELS : 10;
   localparam int AW        = LVW + NW;
   localparam int ANC_DEPTH = LEVELS * (1 << NW);

   typedef struct packed {
      logic          loaded;
      logic [DW-1:0] depth;
      logic [31:0]   root_dist;
   } info_type;

   typedef struct packed {
      logic          valid;
      logic [NW-1:0] idx;
   } anc_type;

   info_type info_mem [0:MAX_NODES-1];
   anc_type  anc_mem  [0:ANC_DEPTH-1];

   logic [1:0]           op_ff, op_in;
   logic [9:0]           a_ff, a_in, b_ff, b_in;
   logic [15:0]          w_ff, w_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [NW-1:0]        u_ff, u_in, v_ff, v_in;
   logic                 cv_ff, cv_in;
   logic [LVW-1:0]       lv_ff, lv_in;
   anc_type              e_ff, e_in;
   info_type             ia_ff, ia_in, ib_ff, ib_in, il_ff, il_in;
   logic [NW-1:0]        clr_ff, clr_in;
   info_type             info_q_ff;
   anc_type              qa_ff, qb_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           st_ff, st_in;
   logic [9:0]           lca_ff, lca_in, anc_ff, anc_in;
   logic [10:0]          hop_ff, hop_in;
   logic [31:0]          wd_ff, wd_in, da_ff, da_in, db_ff, db_in;

   logic                 info_rd;
   logic [NW-1:0]        info_ra;
   logic                 info_we;
   logic [NW-1:0]        info_wa;
   info_type             info_wd;
   logic                 anc_rd;
   logic [AW-1:0]        anc_ra, anc_rb;
   logic                 anc_we;
   logic [AW-1:0]        anc_wa;
   anc_type              anc_wd;

   logic [NW-1:0]        climb_n;
   logic                 res_load;
   logic [31:0]          da_w, db_w, hop_full;
   logic                 a_range, b_range;

   assign climb_n  = cv_ff ? v_ff : u_ff;
   assign a_range  = (32'(a_ff) < MAX_NODES);
   assign b_range  = (32'(b_ff) < MAX_NODES);
   assign da_w     = ia_ff.root_dist - il_ff.root_dist;
   assign db_w     = ib_ff.root_dist - il_ff.root_dist;
   assign hop_full = 32'(ia_ff.depth) + 32'(ib_ff.depth) - (32'(il_ff.depth) << 1);
   assign res_load = (cmd.code == CMD_RES_PLAIN) || (cmd.code == CMD_RES_ANC) ||
                     (cmd.code == CMD_RES_PAIR);

   always_comb begin
      flags.op         = op_ff;
      flags.a_range    = a_range;
      flags.a_loaded   = a_range && ia_ff.loaded;
      flags.b_ok       = b_range && ib_ff.loaded;
      flags.is_root    = (a_ff == root_node);
      flags.depth_full = &ib_ff.depth;
      flags.k_gt_depth = (32'(k_ff) > 32'(ia_ff.depth));
      flags.k_zero     = (k_ff == '0);
      flags.k_bit0     = k_ff[0];
      flags.q_valid    = qa_ff.valid;
      flags.lv_last    = (lv_ff == LVW'(LEVELS - 1));
      flags.lv_zero    = (lv_ff == '0);
      flags.u_eq_v     = (u_ff == v_ff);
      flags.final_ok   = qa_ff.valid && (qa_ff == qb_ff);
      flags.l_loaded   = il_ff.loaded;
      flags.clr_last   = (clr_ff == NW'(MAX_NODES - 1));
      flags.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      op_in = op_ff;  a_in = a_ff;  b_in = b_ff;  w_in = w_ff;  k_in = k_ff;
      u_in = u_ff;  v_in = v_ff;  cv_in = cv_ff;  lv_in = lv_ff;  e_in = e_ff;
      ia_in = ia_ff;  ib_in = ib_ff;  il_in = il_ff;  clr_in = clr_ff;
      info_rd = 1'b0;  info_ra = '0;  info_we = 1'b0;  info_wa = '0;  info_wd = '0;
      anc_rd = 1'b0;  anc_ra = '0;  anc_rb = '0;
      anc_we = 1'b0;  anc_wa = '0;  anc_wd = '0;
      st_in = st_ff;  lca_in = lca_ff;  hop_in = hop_ff;  wd_in = wd_ff;
      da_in = da_ff;  db_in = db_ff;  anc_in = anc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (cmd.code)
         CMD_NOP: ;
         CMD_CLEAR: begin
            info_we = 1'b1;
            info_wa = clr_ff;
            clr_in  = clr_ff + 1'b1;
         end
         CMD_LATCH: begin
            op_in   = req_op;
            a_in    = req_node_a;
            b_in    = req_node_b;
            w_in    = req_edge_weight;
            k_in    = KW'(req_steps_up);
            info_rd = 1'b1;
            info_ra = NW'(req_node_a);
         end
         CMD_RD_B: begin
            ia_in   = info_q_ff;
            info_rd = 1'b1;
            info_ra = NW'(b_ff);
         end
         CMD_GET_B: ib_in = info_q_ff;
         CMD_INS_ROOT: begin
            info_we = 1'b1;
            info_wa = NW'(a_ff);
            info_wd = '{loaded: 1'b1, depth: '0, root_dist: '0};
            lv_in   = '0;
         end
         CMD_ZERO_ANC: begin
            anc_we = 1'b1;
            anc_wa = {lv_ff, NW'(a_ff)};
            lv_in  = lv_ff + 1'b1;
         end
         CMD_INS_CHILD: begin
            info_we = 1'b1;
            info_wa = NW'(a_ff);
            info_wd = '{loaded: 1'b1, depth: ib_ff.depth + 1'b1,
                        root_dist: ib_ff.root_dist + {{16{w_ff[15]}}, w_ff}};
            anc_we  = 1'b1;
            anc_wa  = {LVW'(0), NW'(a_ff)};
            anc_wd  = '{valid: 1'b1, idx: NW'(b_ff)};
            e_in    = '{valid: 1'b1, idx: NW'(b_ff)};
            lv_in   = LVW'(1);
         end
         CMD_BUILD_RD: begin
            anc_rd = e_ff.valid;
            anc_ra = {lv_ff - 1'b1, e_ff.idx};
         end
         CMD_BUILD_WR: begin
            anc_we = 1'b1;
            anc_wa = {lv_ff, NW'(a_ff)};
            anc_wd = e_ff.valid ? qa_ff : '0;
            e_in   = e_ff.valid ? qa_ff : '0;
            lv_in  = lv_ff + 1'b1;
         end
         CMD_PAIR_SETUP: begin
            u_in  = NW'(a_ff);
            v_in  = NW'(b_ff);
            lv_in = '0;
            if (ia_ff.depth > ib_ff.depth) begin
               k_in  = KW'(ia_ff.depth - ib_ff.depth);
               cv_in = 1'b0;
            end else begin
               k_in  = KW'(ib_ff.depth - ia_ff.depth);
               cv_in = 1'b1;
            end
         end
         CMD_K_SETUP: begin
            u_in  = NW'(a_ff);
            cv_in = 1'b0;
            lv_in = '0;
         end
         CMD_CLIMB_STEP: begin
            if (k_ff[0]) begin
               anc_rd = 1'b1;
               anc_ra = {lv_ff, climb_n};
            end else begin
               k_in  = k_ff >> 1;
               lv_in = lv_ff + 1'b1;
            end
         end
         CMD_CLIMB_USE: begin
            if (cv_ff) v_in = qa_ff.idx;
            else       u_in = qa_ff.idx;
            k_in  = k_ff >> 1;
            lv_in = lv_ff + 1'b1;
         end
         CMD_LIFT_INIT: lv_in = LVW'(LEVELS - 1);
         CMD_LIFT_RD, CMD_FINAL_RD: begin
            anc_rd = 1'b1;
            anc_ra = {(cmd.code == CMD_FINAL_RD) ? LVW'(0) : lv_ff, u_ff};
            anc_rb = {(cmd.code == CMD_FINAL_RD) ? LVW'(0) : lv_ff, v_ff};
         end
         CMD_LIFT_USE: begin
            if (qa_ff != qb_ff && qa_ff.valid && qb_ff.valid) begin
               u_in = qa_ff.idx;
               v_in = qb_ff.idx;
            end
            lv_in = lv_ff - 1'b1;
         end
         CMD_FINAL_USE: u_in = qa_ff.idx;
         CMD_L_RD: begin
            info_rd = 1'b1;
            info_ra = u_ff;
         end
         CMD_L_GET: il_in = info_q_ff;
         CMD_RES_PLAIN: begin
            st_in = cmd.status;  lca_in = '0;  hop_in = '0;  wd_in = '0;
            da_in = '0;  db_in = '0;  anc_in = '0;
         end
         CMD_RES_ANC: begin
            st_in = ST_OK;  lca_in = '0;  hop_in = '0;  wd_in = '0;
            da_in = '0;  db_in = '0;  anc_in = 10'(u_ff);
         end
         CMD_RES_PAIR: begin
            st_in  = ST_OK;
            lca_in = 10'(u_ff);
            hop_in = 11'(hop_full);
            wd_in  = da_w + db_w;
            da_in  = da_w;
            db_in  = db_w;
            anc_in = '0;
         end
         default: ;
      endcase
      if (res_load) rsp_valid_in = 1'b1;
   end

   // node records and ancestor table, read data registered
   always_ff @(posedge clock) begin
      if (info_we) info_mem[info_wa] <= info_wd;
      if (info_rd) info_q_ff <= info_mem[info_ra];
   end

   always_ff @(posedge clock) begin
      if (anc_we) anc_mem[anc_wa] <= anc_wd;
      if (anc_rd) begin
         qa_ff <= anc_mem[anc_ra];
         qb_ff <= anc_mem[anc_rb];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;  a_ff <= a_in;  b_ff <= b_in;  w_ff <= w_in;  k_ff <= k_in;
      u_ff <= u_in;  v_ff <= v_in;  cv_ff <= cv_in;  lv_ff <= lv_in;  e_ff <= e_in;
      ia_ff <= ia_in;  ib_ff <= ib_in;  il_ff <= il_in;
      st_ff <= st_in;  lca_ff <= lca_in;  hop_ff <= hop_in;  wd_ff <= wd_in;
      da_ff <= da_in;  db_ff <= db_in;  anc_ff <= anc_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = st_ff;
   assign rsp_lca_node        = lca_ff;
   assign rsp_hop_distance    = hop_ff;
   assign rsp_weight_distance = wd_ff;
   assign rsp_a_to_lca        = da_ff;
   assign rsp_b_to_lca        = db_ff;
   assign rsp_ancestor_node   = anc_ff;

endmodule
`default_nettype wire

// ===== design/tree_lca_binary_lifting.sv =====
// Weighted tree store with binary-lifting LCA and k-th ancestor queries.
// req_* beats carry one op: insert (node_a below parent node_b, edge_weight),
// pair query (node_a, node_b) or k-th ancestor query (node_a, steps_up).
// Each beat yields exactly one rsp_* beat; fields not used by the op are 0.
// The root index is set through the APB port (register 0, byte address 0).
// One item at a time: req_stall is high from acceptance until the result is
// placed in the output register. Cost is set by the walk of the ancestor
// table, each read split into a read state and a use state. A rejected item
// goes straight to its result; a root insert zeroes its ancestor row, a child
// insert builds its row level by level, a k-th query climbs, and a pair query
// climbs and, unless the nodes then meet, lifts and makes a final check.
// A finished result sits in the output register; the next item is accepted
// meanwhile and only waits at its own result while rsp_stall holds the first.
// After reset a clearing pass over all MAX_NODES records marks every node
// unloaded; req_stall is high during it. root_node resets to 0.
`default_nettype none
module tree_lca_binary_lifting #(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 11
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                psel,
   input  wire                penable,
   input  wire                pwrite,
   input  wire  [2:0]         paddr,
   input  wire  [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [1:0]         req_op,
   input  wire  [9:0]         req_node_a,
   input  wire  [9:0]         req_node_b,
   input  wire  signed [15:0] req_edge_weight,
   input  wire  [9:0]         req_steps_up,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [9:0]         rsp_lca_node,
   output logic [10:0]        rsp_hop_distance,
   output logic signed [31:0] rsp_weight_distance,
   output logic signed [31:0] rsp_a_to_lca,
   output logic signed [31:0] rsp_b_to_lca,
   output logic [9:0]         rsp_ancestor_node
);
   import tlca_pkg::*;

   logic [9:0] root_ff, root_in;
   cmd_type    cmd;
   flags_type  flags;
   logic       wr_root;

   assign pready  = 1'b1;
   assign wr_root = psel && penable && pwrite && (paddr[2] == REG_ROOT);
   assign root_in = wr_root ? pwdata[9:0] : root_ff;
   assign prdata  = (paddr[2] == REG_ROOT) ? {22'd0, root_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) root_ff <= '0;
      else       root_ff <= root_in;
   end

   tlca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .flags     (flags),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   tlca_dp #(
      .MAX_NODES (MAX_NODES),
      .LEVELS    (LEVELS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .flags               (flags),
      .root_node           (root_ff),
      .req_op              (req_op),
      .req_node_a          (req_node_a),
      .req_node_b          (req_node_b),
      .req_edge_weight     (req_edge_weight),
      .req_steps_up        (req_steps_up),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_lca_node        (rsp_lca_node),
      .rsp_hop_distance    (rsp_hop_distance),
      .rsp_weight_distance (rsp_weight_distance),
      .rsp_a_to_lca        (rsp_a_to_lca),
      .rsp_b_to_lca        (rsp_b_to_lca),
      .rsp_ancestor_node   (rsp_ancestor_node)
   );

   // clearing pass holds off input right after reset
   a_clear_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input accepted during clearing pass");

   // an accepted beat keeps the block busy in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second beat accepted while one is in work");

   // a result is only written into a free output register
   a_res_free: assert property (@(posedge clock) disable iff (reset)
      ((cmd.code == CMD_RES_PLAIN) || (cmd.code == CMD_RES_ANC) ||
       (cmd.code == CMD_RES_PAIR)) |-> (!rsp_valid || !rsp_stall))
      else $error("result overwrote a stalled beat");

   // no result may appear while the node store is still being cleared
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.code == CMD_CLEAR) |-> !rsp_valid)
      else $error("result during clearing pass");

endmodule
`default_nettype wire
